/* rtl/midi_track_event_parser_assert.svh */
// Assertion macros for the MIDI track parser RTL.
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MTEP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define MTEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mtep_pkg.sv */
// Types, codes and constants for the MIDI track event parser.
package mtep_pkg;

    localparam int TICK_WIDTH_DEF       = 32;
    localparam int LENGTH_MAX_BYTES_DEF = 4;

    localparam int LEN_W      = 28;
    localparam int TICK_OUT_W = 32;

    // result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] ST_SYSTEM    = 8'hF0;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [3:0] TYPE_PROGRAM = 4'hC;
    localparam logic [3:0] TYPE_PRESS   = 4'hD;

    typedef enum logic [3:0] {
        PH_DELTA     = 4'd0,
        PH_STATUS    = 4'd1,
        PH_DATA0     = 4'd2,
        PH_DATA1     = 4'd3,
        PH_META_TYPE = 4'd4,
        PH_META_LEN  = 4'd5,
        PH_SYSEX_LEN = 4'd6,
        PH_PAYLOAD   = 4'd7,
        PH_EOT_SKIP  = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        KIND_CHANNEL = 3'd0,
        KIND_META    = 3'd1,
        KIND_SYSEX   = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_END     = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ERR_TRUNC_DELTA   = 4'd0,
        ERR_TRUNC_EVENT   = 4'd1,
        ERR_TRUNC_META    = 4'd2,
        ERR_TRUNC_EOT     = 4'd3,
        ERR_TRUNC_META_PL = 4'd4,
        ERR_TRUNC_SYSEX   = 4'd5,
        ERR_TRUNC_DATA    = 4'd6,
        ERR_NO_RUNNING    = 4'd7,
        ERR_UNEXPECTED    = 4'd8
    } err_t;

    typedef struct packed {
        kind_t                   kind;
        logic [TICK_OUT_W-1:0]   tick;
        logic [7:0]              status;
        logic [7:0]              meta_kind;
        logic [7:0]              data_first;
        logic [7:0]              data_second;
        logic [LEN_W-1:0]        payload_length;
        logic [7:0]              payload_byte;
        err_t                    error_code;
        logic                    run_last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } res_pair_t;

    typedef struct packed {
        logic at_reset;
        logic ignoring;
    } core_status_t;

endpackage

/* rtl/mtep_core.sv */
// Parser state registers and the combinational per-byte step logic.
module mtep_core #(
    parameter int TICK_WIDTH       = mtep_pkg::TICK_WIDTH_DEF,
    parameter int LENGTH_MAX_BYTES = mtep_pkg::LENGTH_MAX_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            byte_in,
    input  logic                  last_in,
    output mtep_pkg::res_pair_t   pair,
    output mtep_pkg::core_status_t core_st
);

    localparam int LW = mtep_pkg::LEN_W;
    localparam int SW = ((TICK_WIDTH > LW) ? TICK_WIDTH : LW) + 1;
    localparam logic [SW-1:0] TICK_MAX_EXT = {{(SW-TICK_WIDTH){1'b0}}, {TICK_WIDTH{1'b1}}};

    mtep_pkg::phase_t        phase_reg, phase_next;
    logic [LW-1:0]           acc_reg, acc_next;
    logic [2:0]              cnt_reg, cnt_next;
    logic [TICK_WIDTH-1:0]   tick_reg, tick_next;
    logic [7:0]              run_reg, run_next;
    logic [7:0]              cur_reg, cur_next;
    logic [7:0]              meta_reg, meta_next;
    logic [7:0]              held_reg, held_next;
    logic [LW-1:0]           rem_reg, rem_next;
    logic                    ign_reg, ign_next;

    logic [LW-1:0]           len_acc;
    logic [2:0]              len_cnt;
    logic                    len_done;
    logic                    len_long;
    logic [SW-1:0]           tick_sum;
    logic [TICK_WIDTH-1:0]   tick_sat;
    logic [TICK_WIDTH-1:0]   tick_res;
    logic [LW-1:0]           rem_dec;

    logic                    do_af;
    logic [7:0]              af_status;
    logic                    do_hdr;
    logic                    hdr_meta;
    logic                    do_item_done;

    logic                    prim_valid;
    mtep_pkg::result_t       prim;
    logic                    term_valid;
    logic                    term_err;
    mtep_pkg::err_t          term_code;
    mtep_pkg::result_t       term;

    assign len_acc  = {acc_reg[LW-8:0], byte_in[6:0]};
    assign len_cnt  = cnt_reg + 3'd1;
    assign len_done = !byte_in[7];
    assign len_long = byte_in[7] && (len_cnt >= 3'(LENGTH_MAX_BYTES));
    assign tick_sum = SW'(tick_reg) + SW'(len_acc);
    assign tick_sat = (tick_sum > TICK_MAX_EXT) ? {TICK_WIDTH{1'b1}}
                                                : tick_sum[TICK_WIDTH-1:0];
    assign rem_dec  = rem_reg - LW'(1);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        tick_next  = tick_reg;
        run_next   = run_reg;
        cur_next   = cur_reg;
        meta_next  = meta_reg;
        held_next  = held_reg;
        rem_next   = rem_reg;
        ign_next   = ign_reg;

        do_af        = 1'b0;
        af_status    = cur_reg;
        do_hdr       = 1'b0;
        hdr_meta     = 1'b0;
        do_item_done = 1'b0;
        prim_valid   = 1'b0;
        prim         = '0;
        term_valid   = 1'b0;
        term_err     = 1'b0;
        term_code    = mtep_pkg::ERR_TRUNC_DELTA;

        if (!ign_reg)
        begin
            unique case (phase_reg)
                mtep_pkg::PH_DELTA:
                begin
                    acc_next = len_acc;
                    cnt_next = len_cnt;
                    if (len_long)
                    begin
                        term_valid = 1'b1;
                        term_err   = 1'b1;
                        term_code  = mtep_pkg::ERR_TRUNC_DELTA;
                    end
                    else if (len_done)
                    begin
                        tick_next  = tick_sat;
                        phase_next = mtep_pkg::PH_STATUS;
                        if (last_in)
                        begin
                            term_valid = 1'b1;
                            term_err   = 1'b1;
                            term_code  = mtep_pkg::ERR_TRUNC_EVENT;
                        end
                    end
                    else if (last_in)
                    begin
                        term_valid = 1'b1;
                        term_err   = 1'b1;
                        term_code  = mtep_pkg::ERR_TRUNC_DELTA;
                    end
                end
                mtep_pkg::PH_STATUS:
                begin
                    if (byte_in == mtep_pkg::ST_META)
                    begin
                        run_next   = '0;
                        cur_next   = mtep_pkg::ST_META;
                        phase_next = mtep_pkg::PH_META_TYPE;
                        if (last_in)
                        begin
                            term_valid = 1'b1;
                            term_err   = 1'b1;
                            term_code  = mtep_pkg::ERR_TRUNC_META;
                        end
                    end
                    else if (byte_in == mtep_pkg::ST_SYSEX || byte_in == mtep_pkg::ST_SYSEX_ESC)
                    begin
                        run_next   = '0;
                        cur_next   = byte_in;
                        phase_next = mtep_pkg::PH_SYSEX_LEN;
                        acc_next   = '0;
                        cnt_next   = '0;
                        if (last_in)
                        begin
                            term_valid = 1'b1;
                            term_err   = 1'b1;
                            term_code  = mtep_pkg::ERR_TRUNC_SYSEX;
                        end
                    end
                    else if (byte_in[7])
                    begin
                        cur_next   = byte_in;
                        run_next   = byte_in;
                        phase_next = mtep_pkg::PH_DATA0;
                        if (last_in)
                        begin
                            term_valid = 1'b1;
                            term_err   = 1'b1;
                            term_code  = mtep_pkg::ERR_TRUNC_DATA;
                        end
                    end
                    else if (run_reg == '0)
                    begin
                        term_valid = 1'b1;
                        term_err   = 1'b1;
                        term_code  = mtep_pkg::ERR_NO_RUNNING;
                    end
                    else
                    begin
                        // running status: this byte is already the first data byte
                        cur_next  = run_reg;
                        held_next = byte_in;
                        do_af     = 1'b1;
                        af_status = run_reg;
                    end
                end
                mtep_pkg::PH_DATA0:
                begin
                    held_next = byte_in;
                    do_af     = 1'b1;
                    af_status = cur_reg;
                end
                mtep_pkg::PH_DATA1:
                begin
                    prim_valid       = 1'b1;
                    prim.kind        = mtep_pkg::KIND_CHANNEL;
                    prim.status      = cur_reg;
                    prim.data_first  = held_reg;
                    prim.data_second = byte_in;
                    do_item_done     = 1'b1;
                end
                mtep_pkg::PH_META_TYPE:
                begin
                    meta_next  = byte_in;
                    phase_next = mtep_pkg::PH_META_LEN;
                    acc_next   = '0;
                    cnt_next   = '0;
                    if (last_in)
                    begin
                        term_valid = 1'b1;
                        term_err   = 1'b1;
                        term_code  = mtep_pkg::ERR_TRUNC_META;
                    end
                end
                mtep_pkg::PH_META_LEN:
                begin
                    acc_next = len_acc;
                    cnt_next = len_cnt;
                    if (len_long || (!len_done && last_in))
                    begin
                        term_valid = 1'b1;
                        term_err   = 1'b1;
                        term_code  = mtep_pkg::ERR_TRUNC_META;
                    end
                    else if (len_done && meta_reg == mtep_pkg::META_EOT)
                    begin
                        if (len_acc == '0)
                        begin
                            term_valid = 1'b1;
                        end
                        else
                        begin
                            rem_next   = len_acc;
                            phase_next = mtep_pkg::PH_EOT_SKIP;
                            if (last_in)
                            begin
                                term_valid = 1'b1;
                                term_err   = 1'b1;
                                term_code  = mtep_pkg::ERR_TRUNC_EOT;
                            end
                        end
                    end
                    else if (len_done)
                    begin
                        do_hdr   = 1'b1;
                        hdr_meta = 1'b1;
                    end
                end
                mtep_pkg::PH_SYSEX_LEN:
                begin
                    acc_next = len_acc;
                    cnt_next = len_cnt;
                    if (len_long || (!len_done && last_in))
                    begin
                        term_valid = 1'b1;
                        term_err   = 1'b1;
                        term_code  = mtep_pkg::ERR_TRUNC_SYSEX;
                    end
                    else if (len_done)
                    begin
                        do_hdr = 1'b1;
                    end
                end
                mtep_pkg::PH_PAYLOAD:
                begin
                    prim_valid        = 1'b1;
                    prim.kind         = mtep_pkg::KIND_PAYLOAD;
                    prim.status       = cur_reg;
                    prim.meta_kind    = (cur_reg == mtep_pkg::ST_META) ? meta_reg : 8'h00;
                    prim.payload_byte = byte_in;
                    rem_next          = rem_dec;
                    if (rem_dec == '0)
                    begin
                        do_item_done = 1'b1;
                    end
                    else if (last_in)
                    begin
                        term_valid = 1'b1;
                        term_err   = 1'b1;
                        term_code  = (cur_reg == mtep_pkg::ST_META)
                                     ? mtep_pkg::ERR_TRUNC_META_PL
                                     : mtep_pkg::ERR_TRUNC_SYSEX;
                    end
                end
                mtep_pkg::PH_EOT_SKIP:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        term_valid = 1'b1;
                    end
                    else if (last_in)
                    begin
                        term_valid = 1'b1;
                        term_err   = 1'b1;
                        term_code  = mtep_pkg::ERR_TRUNC_EOT;
                    end
                end
                default:
                begin
                    phase_next = mtep_pkg::PH_DELTA;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
            endcase

            // first data byte in hand: decide on one or two data bytes
            if (do_af)
            begin
                if (af_status >= mtep_pkg::ST_SYSTEM)
                begin
                    term_valid = 1'b1;
                    term_err   = 1'b1;
                    term_code  = mtep_pkg::ERR_UNEXPECTED;
                end
                else if (af_status[7:4] == mtep_pkg::TYPE_PROGRAM
                         || af_status[7:4] == mtep_pkg::TYPE_PRESS)
                begin
                    prim_valid       = 1'b1;
                    prim.kind        = mtep_pkg::KIND_CHANNEL;
                    prim.status      = af_status;
                    prim.data_first  = byte_in;
                    do_item_done     = 1'b1;
                end
                else
                begin
                    phase_next = mtep_pkg::PH_DATA1;
                    if (last_in)
                    begin
                        term_valid = 1'b1;
                        term_err   = 1'b1;
                        term_code  = mtep_pkg::ERR_TRUNC_DATA;
                    end
                end
            end

            if (do_hdr)
            begin
                prim_valid          = 1'b1;
                prim.kind           = hdr_meta ? mtep_pkg::KIND_META : mtep_pkg::KIND_SYSEX;
                prim.status         = cur_reg;
                prim.meta_kind      = hdr_meta ? meta_reg : 8'h00;
                prim.payload_length = len_acc;
                if (len_acc == '0)
                begin
                    do_item_done = 1'b1;
                end
                else
                begin
                    rem_next   = len_acc;
                    phase_next = mtep_pkg::PH_PAYLOAD;
                    if (last_in)
                    begin
                        term_valid = 1'b1;
                        term_err   = 1'b1;
                        term_code  = hdr_meta ? mtep_pkg::ERR_TRUNC_META_PL
                                              : mtep_pkg::ERR_TRUNC_SYSEX;
                    end
                end
            end

            if (do_item_done)
            begin
                phase_next = mtep_pkg::PH_DELTA;
                acc_next   = '0;
                cnt_next   = '0;
                if (last_in)
                begin
                    term_valid = 1'b1;
                end
            end
        end

        // results carry the tick before the chunk-end clear below
        tick_res = tick_next;

        if (last_in)
        begin
            phase_next = mtep_pkg::PH_DELTA;
            acc_next   = '0;
            cnt_next   = '0;
            tick_next  = '0;
            run_next   = '0;
            cur_next   = '0;
            meta_next  = '0;
            held_next  = '0;
            rem_next   = '0;
            ign_next   = 1'b0;
        end
        else if (term_valid)
        begin
            ign_next = 1'b1;
        end
    end

    // tick on results is the value after this byte's delta update
    always_comb
    begin
        term            = '0;
        term.kind       = term_err ? mtep_pkg::KIND_ERROR : mtep_pkg::KIND_END;
        term.tick       = mtep_pkg::TICK_OUT_W'(tick_res);
        term.error_code = term_err ? term_code : mtep_pkg::ERR_TRUNC_DELTA;
        term.run_last   = 1'b1;

        pair.count       = {1'b0, prim_valid} + {1'b0, term_valid};
        pair.r1          = term;
        pair.r0          = prim;
        pair.r0.tick     = mtep_pkg::TICK_OUT_W'(tick_res);
        pair.r0.run_last = !term_valid;
        if (!prim_valid)
        begin
            pair.r0 = term;
        end
    end

    assign core_st.at_reset = (phase_reg == mtep_pkg::PH_DELTA) && (cnt_reg == '0)
                              && (tick_reg == '0) && (run_reg == '0) && !ign_reg;
    assign core_st.ignoring = ign_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mtep_pkg::PH_DELTA;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            tick_reg  <= '0;
            run_reg   <= '0;
            cur_reg   <= '0;
            meta_reg  <= '0;
            held_reg  <= '0;
            rem_reg   <= '0;
            ign_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            tick_reg  <= tick_next;
            run_reg   <= run_next;
            cur_reg   <= cur_next;
            meta_reg  <= meta_next;
            held_reg  <= held_next;
            rem_reg   <= rem_next;
            ign_reg   <= ign_next;
        end
    end

endmodule

/* rtl/mtep_outq.sv */
// Result queue: takes up to two results per cycle, delivers one per cycle on pop.
module mtep_outq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push_en,
    input  mtep_pkg::res_pair_t                 push_pair,
    input  logic                                pop,
    output logic                                not_empty,
    output logic [mtep_pkg::OUTQ_CNT_W-1:0]     count,
    output mtep_pkg::result_t                   head
);

    mtep_pkg::result_t                  q_mem [mtep_pkg::OUTQ_DEPTH];
    logic [mtep_pkg::OUTQ_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mtep_pkg::OUTQ_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mtep_pkg::OUTQ_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]                         push_n;
    logic [mtep_pkg::OUTQ_PTR_W-1:0]    wr_ptr_b;

    assign push_n      = push_en ? push_pair.count : 2'd0;
    assign wr_ptr_b    = wr_ptr_reg + mtep_pkg::OUTQ_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + mtep_pkg::OUTQ_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + mtep_pkg::OUTQ_PTR_W'(pop);
    assign cnt_next    = cnt_reg + mtep_pkg::OUTQ_CNT_W'(push_n)
                         - mtep_pkg::OUTQ_CNT_W'(pop);

    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;
    assign head      = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= push_pair.r0;
        end
        if (push_n == 2'd2)
        begin
            q_mem[wr_ptr_b] <= push_pair.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/midi_track_event_parser.sv */
// MIDI track chunk parser: byte input register, step logic, result queue.
// Path: an accepted word is held in the input register, fires when the queue has room.
// Throughput: one input word per cycle while results drain at one per cycle; the four-entry
// result queue sets it, input stalls when a word that may add two results finds no room.
// Reset (rst_n low, async): parser state returns to start of chunk, tick zero, queue empty.
module midi_track_event_parser #(
    parameter int TICK_WIDTH       = mtep_pkg::TICK_WIDTH_DEF,
    parameter int LENGTH_MAX_BYTES = mtep_pkg::LENGTH_MAX_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      in_byte,
    input  logic                            chunk_last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      kind,
    output logic [mtep_pkg::TICK_OUT_W-1:0] tick,
    output logic [7:0]                      status,
    output logic [7:0]                      meta_kind,
    output logic [7:0]                      data_first,
    output logic [7:0]                      data_second,
    output logic [mtep_pkg::LEN_W-1:0]      payload_length,
    output logic [7:0]                      payload_byte,
    output logic [3:0]                      error_code,
    output logic                            run_last
);

`include "midi_track_event_parser_assert.svh"

    logic                                in_full_reg, in_full_next;
    logic [7:0]                          byte_reg;
    logic                                last_reg;
    logic                                accept;
    logic                                fire;
    logic                                room;
    logic                                pop;
    logic [mtep_pkg::OUTQ_CNT_W-1:0]     q_count;
    mtep_pkg::res_pair_t                 pair;
    mtep_pkg::core_status_t              core_st;
    mtep_pkg::result_t                   head;

    // room for the worst case of two results from the held word
    assign room     = (q_count <= mtep_pkg::OUTQ_CNT_W'(mtep_pkg::OUTQ_DEPTH - 2));
    assign fire     = in_full_reg && room;
    assign in_stall = in_full_reg && !room;
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (fire)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
            last_reg <= chunk_last;
        end
    end

    mtep_core #(
        .TICK_WIDTH       (TICK_WIDTH),
        .LENGTH_MAX_BYTES (LENGTH_MAX_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (byte_reg),
        .last_in (last_reg),
        .pair    (pair),
        .core_st (core_st)
    );

    mtep_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (fire),
        .push_pair (pair),
        .pop       (pop),
        .not_empty (out_valid),
        .count     (q_count),
        .head      (head)
    );

    assign kind           = head.kind;
    assign tick           = head.tick;
    assign status         = head.status;
    assign meta_kind      = head.meta_kind;
    assign data_first     = head.data_first;
    assign data_second    = head.data_second;
    assign payload_length = head.payload_length;
    assign payload_byte   = head.payload_byte;
    assign error_code     = head.error_code;
    assign run_last       = head.run_last;

    `MTEP_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= mtep_pkg::OUTQ_CNT_W'(mtep_pkg::OUTQ_DEPTH), "result queue overrun")
    `MTEP_ASSERT_NOW(a_pair_order, fire && pair.count == 2'd2, !pair.r0.run_last && pair.r1.run_last, "run_last misplaced in result pair")
    `MTEP_ASSERT_NOW(a_ignore_quiet, fire && core_st.ignoring, pair.count == 2'd0, "result emitted while skipping rest of chunk")
    `MTEP_ASSERT_NEXT(a_chunk_reset, fire && last_reg, core_st.at_reset, "parser state not cleared at chunk end")
    `MTEP_ASSERT_NOW(a_last_ends, fire && last_reg && !core_st.ignoring, pair.count != 2'd0, "chunk end produced no result")

endmodule
